// ===== rtl/core/apq_pkg.sv =====
package apq_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        REQ_ENQ     = 3'd0,
        REQ_DEQ_MAX = 3'd1,
        REQ_DEQ_IDX = 3'd2,
        REQ_UPDATE  = 3'd3,
        REQ_PEEK    = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RESP
    } state_t;

    // write and shift commands broadcast to every cell
    typedef struct packed {
        logic                     wr_en;
        logic [SLOT_W-1:0]        wr_slot;
        logic                     shift_en;
        logic [SLOT_W-1:0]        shift_pos;
        logic signed [DATA_W-1:0] wr_id;
        logic signed [DATA_W-1:0] wr_prio;
    } cell_ctrl_t;

    // running maximum handed from cell to cell
    typedef struct packed {
        logic                     go;
        logic                     has;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] id;
        logic signed [DATA_W-1:0] prio;
    } scan_tok_t;

endpackage

// ===== rtl/core/apq_if.sv =====
interface apq_req_if;
    logic                             valid;
    logic                             ready;
    logic [2:0]                       req_type;
    logic [apq_pkg::SLOT_W-1:0]       slot_index;
    logic signed [apq_pkg::DATA_W-1:0] item_id;
    logic signed [apq_pkg::DATA_W-1:0] item_priority;

    modport source (output valid, req_type, slot_index, item_id, item_priority,
                    input ready);
    modport sink (input valid, req_type, slot_index, item_id, item_priority,
                  output ready);
endinterface

interface apq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic signed [apq_pkg::DATA_W-1:0] out_id;
    logic signed [apq_pkg::DATA_W-1:0] out_priority;
    logic [apq_pkg::SLOT_W-1:0]        out_slot;
    logic [apq_pkg::COUNT_W-1:0]       entry_count;

    modport source (output valid, status, out_id, out_priority, out_slot, entry_count,
                    input ready);
    modport sink (input valid, status, out_id, out_priority, out_slot, entry_count,
                  output ready);
endinterface

// ===== rtl/core/apq_cell.sv =====
module apq_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [apq_pkg::SLOT_W-1:0]        cell_idx,
    input  logic [apq_pkg::COUNT_W-1:0]       count,
    input  apq_pkg::cell_ctrl_t               ctrl,
    input  logic signed [apq_pkg::DATA_W-1:0] nbr_id,
    input  logic signed [apq_pkg::DATA_W-1:0] nbr_prio,
    input  apq_pkg::scan_tok_t                tok_in,
    output apq_pkg::scan_tok_t                tok_out,
    output logic signed [apq_pkg::DATA_W-1:0] id,
    output logic signed [apq_pkg::DATA_W-1:0] prio
);

    logic signed [apq_pkg::DATA_W-1:0] id_reg;
    logic signed [apq_pkg::DATA_W-1:0] prio_reg;
    apq_pkg::scan_tok_t                tok_reg;
    apq_pkg::scan_tok_t                tok_next;
    logic                              active;
    logic                              better;

    // entry storage: direct write or shift down from the next cell
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en && ctrl.wr_slot == cell_idx)
        begin
            id_reg   <= ctrl.wr_id;
            prio_reg <= ctrl.wr_prio;
        end
        else if (ctrl.shift_en && cell_idx >= ctrl.shift_pos)
        begin
            id_reg   <= nbr_id;
            prio_reg <= nbr_prio;
        end
    end

    // compare own entry with the running maximum
    assign active = {1'b0, cell_idx} < count;
    assign better = !tok_in.has
                    || $signed(prio_reg) > $signed(tok_in.prio)
                    || ($signed(prio_reg) == $signed(tok_in.prio)
                        && $signed(id_reg) > $signed(tok_in.id));

    always_comb
    begin
        tok_next = tok_in;
        if (active && better)
        begin
            tok_next.has  = 1'b1;
            tok_next.slot = cell_idx;
            tok_next.id   = id_reg;
            tok_next.prio = prio_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign id      = id_reg;
    assign prio    = prio_reg;

endmodule

// ===== rtl/core/array_priority_queue.sv =====
// Flow: enqueue, update, dequeue at index and rejected requests go from the request beat
// through EXEC and RESP to the registered result beat; peek and dequeue max also pass
// through SCAN, with the running maximum rippling through one cell per cycle.
// Throughput: one request at a time; a new request is taken while the previous result
// beat still waits.
// Reset: asynchronous, clears the entry count and control; entry contents are undefined.
module array_priority_queue (
    input  logic clk,
    input  logic rst_n,
    apq_req_if.sink   req,
    apq_rsp_if.source rsp
);

    localparam int CAP = apq_pkg::CAPACITY;

    apq_pkg::state_t                   state_reg;
    apq_pkg::state_t                   state_next;
    logic [2:0]                        req_reg;
    logic [apq_pkg::SLOT_W-1:0]        idx_reg;
    logic signed [apq_pkg::DATA_W-1:0] id_reg;
    logic signed [apq_pkg::DATA_W-1:0] prio_reg;
    logic [apq_pkg::COUNT_W-1:0]       count_reg;
    logic [apq_pkg::COUNT_W-1:0]       count_next;

    logic [1:0]                        res_status_reg;
    logic [1:0]                        res_status_next;
    logic signed [apq_pkg::DATA_W-1:0] res_id_reg;
    logic signed [apq_pkg::DATA_W-1:0] res_id_next;
    logic signed [apq_pkg::DATA_W-1:0] res_prio_reg;
    logic signed [apq_pkg::DATA_W-1:0] res_prio_next;
    logic [apq_pkg::SLOT_W-1:0]        res_slot_reg;
    logic [apq_pkg::SLOT_W-1:0]        res_slot_next;

    logic                              out_valid_reg;
    logic [1:0]                        out_status_reg;
    logic signed [apq_pkg::DATA_W-1:0] out_id_reg;
    logic signed [apq_pkg::DATA_W-1:0] out_prio_reg;
    logic [apq_pkg::SLOT_W-1:0]        out_slot_reg;
    logic [apq_pkg::COUNT_W-1:0]       out_count_reg;

    apq_pkg::cell_ctrl_t               ctrl;
    logic                              scan_start;
    logic                              out_load;
    logic                              req_beat;
    logic                              scan_req;
    apq_pkg::scan_tok_t                tok [0:CAP];
    logic signed [apq_pkg::DATA_W-1:0] cell_id   [0:CAP-1];
    logic signed [apq_pkg::DATA_W-1:0] cell_prio [0:CAP-1];

    assign req_beat = req.valid && req.ready;
    assign req.ready = (state_reg == apq_pkg::S_IDLE);
    assign out_load = (state_reg == apq_pkg::S_RESP) && (!out_valid_reg || rsp.ready);
    assign scan_req = (req_reg == apq_pkg::REQ_DEQ_MAX || req_reg == apq_pkg::REQ_PEEK)
                      && count_reg != '0;

    // head of the scan chain
    always_comb
    begin
        tok[0]      = '0;
        tok[0].go   = scan_start;
        tok[0].has  = 1'b0;
    end

    // row of cells
    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        if (i == CAP - 1)
        begin : g_tail
            apq_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (apq_pkg::SLOT_W'(i)),
                .count    (count_reg),
                .ctrl     (ctrl),
                .nbr_id   (cell_id[i]),
                .nbr_prio (cell_prio[i]),
                .tok_in   (tok[i]),
                .tok_out  (tok[i+1]),
                .id       (cell_id[i]),
                .prio     (cell_prio[i])
            );
        end
        else
        begin : g_body
            apq_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (apq_pkg::SLOT_W'(i)),
                .count    (count_reg),
                .ctrl     (ctrl),
                .nbr_id   (cell_id[i+1]),
                .nbr_prio (cell_prio[i+1]),
                .tok_in   (tok[i]),
                .tok_out  (tok[i+1]),
                .id       (cell_id[i]),
                .prio     (cell_prio[i])
            );
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            apq_pkg::S_IDLE:
            begin
                if (req_beat)
                begin
                    state_next = apq_pkg::S_EXEC;
                end
            end
            apq_pkg::S_EXEC:
            begin
                state_next = scan_req ? apq_pkg::S_SCAN : apq_pkg::S_RESP;
            end
            apq_pkg::S_SCAN:
            begin
                if (tok[CAP].go)
                begin
                    state_next = apq_pkg::S_RESP;
                end
            end
            apq_pkg::S_RESP:
            begin
                if (out_load)
                begin
                    state_next = apq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = apq_pkg::S_IDLE;
            end
        endcase
    end

    // request execution and cell commands
    always_comb
    begin
        ctrl            = '0;
        ctrl.wr_id      = id_reg;
        ctrl.wr_prio    = prio_reg;
        scan_start      = 1'b0;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_prio_next   = res_prio_reg;
        res_slot_next   = res_slot_reg;
        case (state_reg)
            apq_pkg::S_EXEC:
            begin
                res_status_next = apq_pkg::ST_OK;
                res_id_next     = '0;
                res_prio_next   = '0;
                res_slot_next   = '0;
                case (req_reg)
                    apq_pkg::REQ_ENQ:
                    begin
                        if (count_reg == apq_pkg::COUNT_W'(CAP))
                        begin
                            res_status_next = apq_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctrl.wr_en   = 1'b1;
                            ctrl.wr_slot = count_reg[apq_pkg::SLOT_W-1:0];
                            count_next   = count_reg + 1'b1;
                        end
                    end
                    apq_pkg::REQ_DEQ_MAX, apq_pkg::REQ_PEEK:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = apq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            scan_start = 1'b1;
                        end
                    end
                    apq_pkg::REQ_DEQ_IDX:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = apq_pkg::ST_EMPTY;
                        end
                        else if (apq_pkg::COUNT_W'(idx_reg) >= count_reg)
                        begin
                            res_status_next = apq_pkg::ST_BADIDX;
                        end
                        else
                        begin
                            res_id_next    = cell_id[idx_reg];
                            res_prio_next  = cell_prio[idx_reg];
                            res_slot_next  = idx_reg;
                            ctrl.shift_en  = 1'b1;
                            ctrl.shift_pos = idx_reg;
                            count_next     = count_reg - 1'b1;
                        end
                    end
                    apq_pkg::REQ_UPDATE:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = apq_pkg::ST_EMPTY;
                        end
                        else if (apq_pkg::COUNT_W'(idx_reg) >= count_reg)
                        begin
                            res_status_next = apq_pkg::ST_BADIDX;
                        end
                        else
                        begin
                            ctrl.wr_en   = 1'b1;
                            ctrl.wr_slot = idx_reg;
                        end
                    end
                    default:
                    begin
                        res_status_next = apq_pkg::ST_OK;
                    end
                endcase
            end
            apq_pkg::S_SCAN:
            begin
                if (tok[CAP].go)
                begin
                    res_id_next   = tok[CAP].id;
                    res_prio_next = tok[CAP].prio;
                    res_slot_next = tok[CAP].slot;
                    if (req_reg == apq_pkg::REQ_DEQ_MAX)
                    begin
                        ctrl.shift_en  = 1'b1;
                        ctrl.shift_pos = tok[CAP].slot;
                        count_next     = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                scan_start = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= apq_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request capture, result staging and output beat
    always_ff @(posedge clk)
    begin
        if (req_beat)
        begin
            req_reg  <= req.req_type;
            idx_reg  <= req.slot_index;
            id_reg   <= req.item_id;
            prio_reg <= req.item_priority;
        end
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_prio_reg   <= res_prio_next;
        res_slot_reg   <= res_slot_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_prio_reg   <= res_prio_reg;
            out_slot_reg   <= res_slot_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.out_id       = out_id_reg;
    assign rsp.out_priority = out_prio_reg;
    assign rsp.out_slot     = out_slot_reg;
    assign rsp.entry_count  = out_count_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= apq_pkg::COUNT_W'(CAP))
        else $error("entry count beyond capacity");

    a_scan_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok[CAP].go |-> state_reg == apq_pkg::S_SCAN)
        else $error("scan result outside scan state");

    a_scan_found: assert property (@(posedge clk) disable iff (!rst_n)
        tok[CAP].go |-> tok[CAP].has)
        else $error("scan finished without a candidate");

    a_req_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat |=> state_reg == apq_pkg::S_EXEC)
        else $error("request beat not executed");

    a_count_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == apq_pkg::S_IDLE || state_reg == apq_pkg::S_RESP) |=> $stable(count_reg))
        else $error("entry count changed outside execution");

endmodule
